/* sv/skmc_pkg.sv */
// skmc_pkg: shared types and constants for the sorted key/value merge block.
// Request and result payload structs and command codes. No dependencies.
`default_nettype none
package skmc_pkg;

  localparam int WORD_BITS = 64;

  localparam logic [1:0] CMD_LOAD_OLDER = 2'd0;
  localparam logic [1:0] CMD_LOAD_NEWER = 2'd1;
  localparam logic [1:0] CMD_MERGE      = 2'd2;

  typedef struct packed {
    logic [1:0]           command;
    logic [WORD_BITS-1:0] entry_key;
    logic [WORD_BITS-1:0] entry_value;
    logic                 entry_is_tombstone;
  } request_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] out_key;
    logic [WORD_BITS-1:0] out_value;
    logic                 out_last;
    logic                 out_empty;
    logic                 load_overflowed;
  } result_t;

endpackage
`default_nettype wire

/* sv/sorted_kv_merge_compact.sv */
// sorted_kv_merge_compact: loads two sorted tables and emits their merge.
// Load request: busy stays low. Merge request: busy through a priming state, then
// the merge steps (older_fill + newer_fill minus equal-key pairs), then one final
// step. Each survivor is held until the next one is found, so results come at most one per
// cycle and the last one is on the ports in the first cycle busy is low. Receiver cannot stall.
// Reset (synchronous, active high) empties both tables and clears the overflow flag.
`default_nettype none
module sorted_kv_merge_compact #(
  parameter int TABLE_DEPTH = 32,
  parameter int KEY_BITS    = 64,
  parameter int VALUE_BITS  = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire skmc_pkg::request_t req,
  output      logic              out_valid,
  output      skmc_pkg::result_t rsp
);

  localparam int IDX_W   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_BITS + VALUE_BITS + 1;
  localparam logic [FILL_W-1:0] FULL = FILL_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]          state;
  logic [FILL_W-1:0]   older_fill;
  logic [FILL_W-1:0]   newer_fill;
  logic                overflow_seen;
  logic [FILL_W-1:0]   i;
  logic [FILL_W-1:0]   j;
  logic [FILL_W-1:0]   i_next;
  logic [FILL_W-1:0]   j_next;
  logic                pend_valid;
  logic [KEY_BITS-1:0] pend_key;
  logic [VALUE_BITS-1:0] pend_value;

  logic                accept;
  logic                wr_older;
  logic                wr_newer;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  older_rd;
  logic [ENTRY_W-1:0]  newer_rd;
  logic [KEY_BITS-1:0] older_key;
  logic [KEY_BITS-1:0] newer_key;
  logic                i_live;
  logic                j_live;
  logic                take_old;
  logic                keys_equal;
  logic                step_done;
  logic [ENTRY_W-1:0]  chosen;
  logic                chosen_tomb;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign wr_older = accept && (req.command == skmc_pkg::CMD_LOAD_OLDER) && (older_fill < FULL);
  assign wr_newer = accept && (req.command == skmc_pkg::CMD_LOAD_NEWER) && (newer_fill < FULL);
  assign wr_data  = {req.entry_key[KEY_BITS-1:0], req.entry_value[VALUE_BITS-1:0],
                     req.entry_is_tombstone};

  // entry layout: {key, value, tombstone}
  assign older_key  = older_rd[ENTRY_W-1 -: KEY_BITS];
  assign newer_key  = newer_rd[ENTRY_W-1 -: KEY_BITS];
  assign i_live     = (i < older_fill);
  assign j_live     = (j < newer_fill);
  assign take_old   = i_live && (!j_live || (older_key < newer_key));
  assign keys_equal = i_live && j_live && (older_key == newer_key);
  assign step_done  = !i_live && !j_live;
  assign chosen     = take_old ? older_rd : newer_rd;
  assign chosen_tomb = chosen[0];

  always_comb begin
    i_next = '0;
    j_next = '0;
    if (state == ST_MERGE && !step_done) begin
      i_next = i + FILL_W'(take_old || keys_equal);
      j_next = j + FILL_W'(!take_old);
    end
  end

  skmc_table #(.DEPTH(TABLE_DEPTH), .ENTRY_BITS(ENTRY_W)) u_older (
    .clk     (clk),
    .wr_en   (wr_older),
    .wr_addr (older_fill[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (i_next[IDX_W-1:0]),
    .rd_data (older_rd)
  );

  skmc_table #(.DEPTH(TABLE_DEPTH), .ENTRY_BITS(ENTRY_W)) u_newer (
    .clk     (clk),
    .wr_en   (wr_newer),
    .wr_addr (newer_fill[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (j_next[IDX_W-1:0]),
    .rd_data (newer_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      older_fill    <= '0;
      newer_fill    <= '0;
      overflow_seen <= 1'b0;
      i             <= '0;
      j             <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          out_valid <= 1'b0;
          i <= '0;
          j <= '0;
          pend_valid <= 1'b0;
          if (accept) begin
            case (req.command)
              skmc_pkg::CMD_LOAD_OLDER: begin
                if (older_fill < FULL) older_fill <= older_fill + FILL_W'(1);
                else overflow_seen <= 1'b1;
              end
              skmc_pkg::CMD_LOAD_NEWER: begin
                if (newer_fill < FULL) newer_fill <= newer_fill + FILL_W'(1);
                else overflow_seen <= 1'b1;
              end
              skmc_pkg::CMD_MERGE: state <= ST_PRIME;
              default: ;
            endcase
          end
        end
        ST_PRIME: begin
          out_valid <= 1'b0;
          state <= ST_MERGE;
        end
        ST_MERGE: begin
          i <= i_next;
          j <= j_next;
          if (step_done) begin
            out_valid               <= 1'b1;
            rsp.out_key             <= pend_valid ? skmc_pkg::WORD_BITS'(pend_key) : '0;
            rsp.out_value           <= pend_valid ? skmc_pkg::WORD_BITS'(pend_value) : '0;
            rsp.out_last            <= 1'b1;
            rsp.out_empty           <= !pend_valid;
            rsp.load_overflowed     <= overflow_seen;
            pend_valid    <= 1'b0;
            older_fill    <= '0;
            newer_fill    <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end else if (!chosen_tomb) begin
            // hold the newest survivor back until we know whether it is the last
            out_valid           <= pend_valid;
            rsp.out_key         <= skmc_pkg::WORD_BITS'(pend_key);
            rsp.out_value       <= skmc_pkg::WORD_BITS'(pend_value);
            rsp.out_last        <= 1'b0;
            rsp.out_empty       <= 1'b0;
            rsp.load_overflowed <= overflow_seen;
            pend_valid <= 1'b1;
            pend_key   <= chosen[ENTRY_W-1 -: KEY_BITS];
            pend_value <= chosen[VALUE_BITS:1];
          end else begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.out_empty |-> rsp.out_last)
    else $error("empty marker without last");

  a_last_ends_merge: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.out_last |-> state == ST_IDLE)
    else $error("last result while merge still running");

  a_ptr_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |-> (i <= older_fill) && (j <= newer_fill))
    else $error("merge pointer past fill count");

  a_merge_goes_busy: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == skmc_pkg::CMD_MERGE |=> busy && !out_valid)
    else $error("merge request did not enter priming");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (older_fill <= FULL) && (newer_fill <= FULL))
    else $error("fill count beyond table depth");

endmodule
`default_nettype wire

/* sv/skmc_table.sv */
// skmc_table: one key/value table, a single-port-write, single-read memory
// with registered read data. Standalone, no package use.
`default_nettype none
module skmc_table #(
  parameter int DEPTH      = 32,
  parameter int ENTRY_BITS = 129
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [ENTRY_BITS-1:0]                 wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [ENTRY_BITS-1:0]                 rd_data
);

  logic [ENTRY_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* tb/sorted_kv_merge_compact_tb.sv */
// sorted_kv_merge_compact_tb: self-checking bench for the two-table merge compaction block.
// Drives load/merge requests, predicts merged output, checks each result strobe.
// Depends on skmc_pkg and sorted_kv_merge_compact.
module sorted_kv_merge_compact_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 32;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class compaction_model;
    logic [63:0] keys [2][TABLE_SLOTS];
    logic [63:0] vals [2][TABLE_SLOTS];
    bit          tomb [2][TABLE_SLOTS];
    int          fill [2];
    bit          overflow;
    skmc_pkg::result_t expected_entries [$];
    int          mismatches;
    int          checked;
    int          merges;
    int          overflow_merges;

    function new();
      fill[0] = 0;
      fill[1] = 0;
      overflow = 1'b0;
      mismatches = 0;
      checked = 0;
      merges = 0;
      overflow_merges = 0;
    endfunction

    function void note_request(skmc_pkg::request_t r);
      int      t;
      int      i;
      int      j;
      bit      take_old;
      skmc_pkg::result_t e;
      skmc_pkg::result_t batch [$];
      if (r.command == skmc_pkg::CMD_LOAD_OLDER || r.command == skmc_pkg::CMD_LOAD_NEWER) begin
        t = (r.command == skmc_pkg::CMD_LOAD_NEWER) ? 1 : 0;
        if (fill[t] >= TABLE_SLOTS) begin
          overflow = 1'b1;
        end else begin
          keys[t][fill[t]] = r.entry_key;
          vals[t][fill[t]] = r.entry_value;
          tomb[t][fill[t]] = r.entry_is_tombstone;
          fill[t]++;
        end
      end else if (r.command == skmc_pkg::CMD_MERGE) begin
        i = 0;
        j = 0;
        while (i < fill[0] || j < fill[1]) begin
          if (i >= fill[0]) begin
            take_old = 1'b0;
          end else if (j >= fill[1]) begin
            take_old = 1'b1;
          end else if (keys[0][i] < keys[1][j]) begin
            take_old = 1'b1;
          end else begin
            take_old = 1'b0;
            // equal keys: newer wins, older is consumed too
            if (keys[0][i] == keys[1][j]) i++;
          end
          e = '0;
          e.load_overflowed = overflow;
          if (take_old) begin
            if (!tomb[0][i]) begin
              e.out_key = keys[0][i];
              e.out_value = vals[0][i];
              batch = {batch, e};
            end
            i++;
          end else begin
            if (!tomb[1][j]) begin
              e.out_key = keys[1][j];
              e.out_value = vals[1][j];
              batch = {batch, e};
            end
            j++;
          end
        end
        if (batch.size() == 0) begin
          e = '0;
          e.out_empty = 1'b1;
          e.load_overflowed = overflow;
          batch = {batch, e};
        end
        for (int k = 0; k < batch.size(); k++) begin
          e = batch[k];
          e.out_last = (k == batch.size() - 1);
          expected_entries = {expected_entries, e};
        end
        merges++;
        if (overflow) overflow_merges++;
        fill[0] = 0;
        fill[1] = 0;
        overflow = 1'b0;
      end
    endfunction

    function void check_result(skmc_pkg::result_t got);
      skmc_pkg::result_t want;
      checked++;
      if (expected_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result key=%h value=%h last=%b empty=%b ovf=%b",
                   got.out_key, got.out_value, got.out_last, got.out_empty,
                   got.load_overflowed);
        return;
      end
      want = expected_entries.pop_front();
      if (got.out_key !== want.out_key || got.out_value !== want.out_value ||
          got.out_last !== want.out_last || got.out_empty !== want.out_empty ||
          got.load_overflowed !== want.load_overflowed) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: exp key=%h value=%h last=%b empty=%b ovf=%b",
                   want.out_key, want.out_value, want.out_last, want.out_empty,
                   want.load_overflowed);
          $display("       got key=%h value=%h last=%b empty=%b ovf=%b",
                   got.out_key, got.out_value, got.out_last, got.out_empty,
                   got.load_overflowed);
        end
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  skmc_pkg::request_t req = '0;
  logic     busy;
  logic     out_valid;
  skmc_pkg::result_t  rsp;

  compaction_model model;
  int items_sent = 0;
  int idle_pct = 0;

  sorted_kv_merge_compact dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .out_valid (out_valid),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) model.note_request(req);
      if (out_valid) model.check_result(rsp);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [63:0] key,
                       input logic [63:0] val, input logic tombstone);
    skmc_pkg::request_t r;
    r.command = cmd;
    r.entry_key = key;
    r.entry_value = val;
    r.entry_is_tombstone = tombstone;
    req <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Both tables walk up from a shared base so equal keys across tables are common;
  // a zero step gives a duplicate within one table, a wrap gives an unsorted table.
  task automatic run_merge_sequence(input int n_old, input int n_new, input int shift,
                                    input int tomb_pct);
    int          i_old;
    int          i_new;
    bit          pick_old;
    logic [63:0] k_old;
    logic [63:0] k_new;
    i_old = 0;
    i_new = 0;
    k_old = rand64();
    k_new = k_old;
    while (i_old < n_old || i_new < n_new) begin
      pick_old = (i_new >= n_new) || (i_old < n_old && $urandom_range(0, 1) == 1);
      if (pick_old) begin
        issue(skmc_pkg::CMD_LOAD_OLDER, k_old, rand64(), $urandom_range(0, 99) < tomb_pct);
        k_old = k_old + (64'($urandom_range(0, 4)) << shift);
        i_old++;
      end else begin
        issue(skmc_pkg::CMD_LOAD_NEWER, k_new, rand64(), $urandom_range(0, 99) < tomb_pct);
        k_new = k_new + (64'($urandom_range(0, 4)) << shift);
        i_new++;
      end
      if ($urandom_range(0, 15) == 0)
        issue(CMD_UNUSED, rand64(), rand64(), 1'($urandom_range(0, 1)));
    end
    issue(skmc_pkg::CMD_MERGE, rand64(), rand64(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int seq;
    int kind;
    int n_old;
    int n_new;
    model = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty merge, key extremes, newer wins, tombstones, unsorted/duplicates
    issue(skmc_pkg::CMD_MERGE, '1, '1, 1'b1);
    issue(skmc_pkg::CMD_LOAD_OLDER, 64'd0, 64'd0, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, 64'd5, '1, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, '1, 64'd1, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd0, 64'haaaa_5555_aaaa_5555, 1'b1);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd3, 64'd3, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd5, 64'h5555_aaaa_5555_aaaa, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, '1, 64'd2, 1'b0);
    issue(CMD_UNUSED, '1, '1, 1'b1);
    issue(skmc_pkg::CMD_MERGE, 64'd0, 64'd0, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, 64'd7, 64'd70, 1'b1);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd9, 64'd90, 1'b1);
    issue(skmc_pkg::CMD_MERGE, 64'd0, 64'd0, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, 64'd9, 64'd19, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, 64'd2, 64'd12, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd4, 64'd14, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd4, 64'd24, 1'b0);
    issue(skmc_pkg::CMD_LOAD_NEWER, 64'd1, 64'd34, 1'b1);
    issue(skmc_pkg::CMD_MERGE, 64'd0, 64'd0, 1'b0);
    issue(skmc_pkg::CMD_LOAD_OLDER, '1 - 64'd1, '1, 1'b0);
    issue(skmc_pkg::CMD_MERGE, 64'd0, 64'd0, 1'b0);

    seq = 0;
    while (items_sent < 100) begin
      case (seq % 3)
        0: idle_pct = 0;
        1: idle_pct = 50;
        default: idle_pct = 31;
      endcase
      kind = $urandom_range(0, 9);
      n_old = $urandom_range(0, 6);
      n_new = $urandom_range(0, 6);
      if (seq == 1 || (seq > 3 && kind == 0)) begin
        n_old = TABLE_SLOTS + $urandom_range(1, 2);
      end else if (seq == 3) begin
        n_new = TABLE_SLOTS + $urandom_range(0, 1);
      end else if (kind == 1) begin
        n_old = $urandom_range(7, TABLE_SLOTS);
      end
      run_merge_sequence(n_old, n_new, (kind < 5) ? 0 : $urandom_range(0, 60),
                         (kind == 2) ? 100 : 20);
      seq++;
    end
    start <= 1'b0;
    idle_pct = 0;

    while (model.expected_entries.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests and %0d merges (%0d after a table overflow)",
             items_sent, model.merges, model.overflow_merges);
    $display("%0d results checked, %0d mismatches, %0d results missing",
             model.checked, model.mismatches, model.expected_entries.size());
    if (model.mismatches == 0 && model.expected_entries.size() == 0) begin
      $display("sorted_kv_merge_compact verification clean");
    end else begin
      $display("sorted_kv_merge_compact verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout waiting for requests or results");
    $display("sorted_kv_merge_compact verification failed");
    $finish;
  end

endmodule
